FILE: sv/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types and constants of the streaming regex matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srm_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int LEN_W           = 4;
    localparam int CHAR_W          = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int MASK_W          = 8;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_END  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHARS     = 3'd0,
        CFG_ANY_MASK  = 3'd1,
        CFG_STAR_MASK = 3'd2,
        CFG_LENGTH    = 3'd3,
        CFG_ANCH_BEG  = 3'd4,
        CFG_ANCH_END  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             anch_start;
        logic             anch_end;
    } t_back_cfg;

endpackage

`default_nettype wire

FILE: sv/srm_front.sv
// ----------------------------------------------------------------------------
// srm_front
// Accepts requests and classifies each text byte against every pattern element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srm_front #(
    parameter int PATTERN_MAX = 8
) (
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_command,
    input  wire logic [srm_pkg::CHAR_W-1:0]          i_text_char,
    input  wire logic [srm_pkg::CHAR_W*PATTERN_MAX-1:0] i_chars,
    input  wire logic [PATTERN_MAX-1:0]              i_any,
    input  wire logic                                i_full,
    output logic                                     o_push,
    output logic [PATTERN_MAX:0]                     o_entry
);
    import srm_pkg::*;

    logic [PATTERN_MAX-1:0] hit;

    // per-element hit vector, the back end needs these bits and the command bit
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            hit[i] = i_any[i] || (i_chars[CHAR_W*i +: CHAR_W] == i_text_char);
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_entry = {i_command, hit};

endmodule

`default_nettype wire

FILE: sv/srm_queue.sv
// ----------------------------------------------------------------------------
// srm_queue
// Short first-in first-out queue between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srm_queue #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty,
    output logic                  o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

`default_nettype wire

FILE: sv/srm_back.sv
// ----------------------------------------------------------------------------
// srm_back
// NFA step over reached pattern positions and registered result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srm_back #(
    parameter int PATTERN_MAX = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_empty,
    input  wire logic [PATTERN_MAX:0]   i_entry,
    output logic                        o_pop,
    input  wire logic [PATTERN_MAX-1:0] i_star,
    input  wire srm_pkg::t_back_cfg     i_cfg,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_done_res,
    output logic                        o_found
);
    import srm_pkg::*;

    localparam int POS_W = PATTERN_MAX + 1;

    // drop positions above len, then spread along starred elements
    function automatic logic [PATTERN_MAX:0] f_close(input logic [PATTERN_MAX:0] s,
                                                     input logic [LEN_W-1:0] len,
                                                     input logic [PATTERN_MAX-1:0] star);
        logic [PATTERN_MAX:0] v;
        v = s;
        for (int j = 0; j <= PATTERN_MAX; j++) begin
            if (LEN_W'(j) > len) v[j] = 1'b0;
        end
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (LEN_W'(i) < len && v[i] && star[i]) v[i+1] = 1'b1;
        end
        return v;
    endfunction

    function automatic logic f_acc(input logic [PATTERN_MAX:0] s,
                                   input logic [LEN_W-1:0] len);
        logic a;
        a = 1'b0;
        for (int j = 0; j <= PATTERN_MAX; j++) begin
            if (LEN_W'(j) == len) a = s[j];
        end
        return a;
    endfunction

    logic [PATTERN_MAX:0]   r_reached;
    logic                   r_match_seen;
    logic                   r_at_start;
    logic                   r_out_valid;
    logic                   r_done;
    logic                   r_found;

    t_cmd                   cmd;
    logic [PATTERN_MAX-1:0] hit;
    logic [LEN_W-1:0]       len;
    logic                   seed;
    logic [PATTERN_MAX:0]   cur, nxt, reached_nx, cur_after;
    logic                   acc_cur, acc_after;
    logic                   match_nx, fin_end;

    assign cmd = t_cmd'(i_entry[PATTERN_MAX]);
    assign hit = i_entry[PATTERN_MAX-1:0];
    assign len = (i_cfg.len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : i_cfg.len;
    assign seed = !i_cfg.anch_start || r_at_start;
    assign o_pop = !i_empty && (!r_out_valid || i_ready);

    always_comb begin
        cur = f_close(r_reached | POS_W'(seed), len, i_star);
        acc_cur = f_acc(cur, len);
        nxt = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (LEN_W'(i) < len && cur[i] && hit[i]) begin
                if (i_star[i]) nxt[i] = 1'b1;
                else           nxt[i+1] = 1'b1;
            end
        end
        reached_nx = f_close(nxt, len, i_star);
        // set seen before the next byte, unanchored start seeds position zero
        cur_after  = f_close(nxt | POS_W'(!i_cfg.anch_start), len, i_star);
        acc_after  = f_acc(cur_after, len);
        match_nx   = r_match_seen || (!i_cfg.anch_end && (acc_cur || acc_after));
        fin_end    = i_cfg.anch_end ? acc_cur : (r_match_seen || acc_cur);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reached    <= POS_W'(1);
            r_match_seen <= 1'b0;
            r_at_start   <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                if (cmd == CMD_END) begin
                    r_reached    <= POS_W'(1);
                    r_match_seen <= 1'b0;
                    r_at_start   <= 1'b1;
                end else begin
                    r_reached    <= reached_nx;
                    r_match_seen <= match_nx;
                    r_at_start   <= 1'b0;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_done  <= (cmd == CMD_END);
            r_found <= (cmd == CMD_END) ? fin_end : (!i_cfg.anch_end && match_nx);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_done_res = r_done;
    assign o_found    = r_found;

    a_end_anchor_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_done && i_cfg.anch_end |-> !r_found)
        else $error("found set on text result with end anchor");

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && cmd == CMD_END |=> r_at_start && !r_match_seen && r_reached == POS_W'(1))
        else $error("matcher not rearmed after end of text");

    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && cmd == CMD_CHAR && r_match_seen && !i_cfg.anch_end |=> r_found)
        else $error("seen match lost on text result");

endmodule

`default_nettype wire

FILE: sv/simple_regex_stream_matcher_unit.sv
// ----------------------------------------------------------------------------
// simple_regex_stream_matcher_unit
// Streaming matcher of a compiled simple regex over a byte stream.
// ----------------------------------------------------------------------------
// result: each accepted request is queued, then popped by the back end, which registers its verdict
// throughput: one request per cycle while the receiver is ready, the NFA step is done in the back end
// a 2-entry queue decouples the byte classifier from the NFA step
// reset: synchronous active low, clears configuration, queue pointers and output valid to zero and rearms the matcher
`timescale 1ns / 1ps
`default_nettype none

module simple_regex_stream_matcher_unit #(
    parameter int PATTERN_MAX = srm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_command,
    input  wire logic [srm_pkg::CHAR_W-1:0]       i_text_char,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_done_res,
    output logic                                  o_found,
    input  wire logic                             i_cfg_we,
    input  wire logic [srm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [srm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import srm_pkg::*;

    localparam int ENTRY_W = PATTERN_MAX + 1;

    logic [CFG_DATA_W-1:0] r_chars;
    logic [MASK_W-1:0]     r_any;
    logic [MASK_W-1:0]     r_star;
    logic [LEN_W-1:0]      r_len;
    logic                  r_anch_start;
    logic                  r_anch_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars      <= '0;
            r_any        <= '0;
            r_star       <= '0;
            r_len        <= '0;
            r_anch_start <= 1'b0;
            r_anch_end   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CHARS:     r_chars      <= i_cfg_data;
                CFG_ANY_MASK:  r_any        <= i_cfg_data[MASK_W-1:0];
                CFG_STAR_MASK: r_star       <= i_cfg_data[MASK_W-1:0];
                CFG_LENGTH:    r_len        <= i_cfg_data[LEN_W-1:0];
                CFG_ANCH_BEG:  r_anch_start <= i_cfg_data[0];
                CFG_ANCH_END:  r_anch_end   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    t_back_cfg          back_cfg;
    logic               push, pop, empty, full;
    logic [ENTRY_W-1:0] push_entry, head_entry;

    assign back_cfg.len        = r_len;
    assign back_cfg.anch_start = r_anch_start;
    assign back_cfg.anch_end   = r_anch_end;

    srm_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_text_char (i_text_char),
        .i_chars     (r_chars[CHAR_W*PATTERN_MAX-1:0]),
        .i_any       (r_any[PATTERN_MAX-1:0]),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    srm_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (head_entry),
        .o_empty (empty),
        .o_full  (full)
    );

    srm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_entry    (head_entry),
        .o_pop      (pop),
        .i_star     (r_star[PATTERN_MAX-1:0]),
        .i_cfg      (back_cfg),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_done_res (o_done_res),
        .o_found    (o_found)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the streaming simple regex matcher. Text streams and end
// markers go in over a valid/ready channel under random bursts and gaps. A
// bit-vector NFA predictor computes the done/found verdict of every request.
// A checker compares each returned verdict with the oldest prediction while
// the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb;
    import srm_pkg::*;

    typedef logic [CHAR_W-1:0] t_text[$];

    typedef struct packed {
        logic done;
        logic found;
    } t_verdict;

    typedef enum int {
        RX_FREE,
        RX_PATTERN,
        RX_MOSTLY,
        RX_COIN
    } t_rx_mode;

    localparam int RANDOM_REQUESTS = 2000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  i_command   = CMD_CHAR;
    logic [CHAR_W-1:0]     i_text_char = '0;
    logic                  i_ready     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = CFG_CHARS;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_ready;
    logic                  o_valid;
    logic                  o_done_res;
    logic                  o_found;

    // predictor copy of the configuration
    logic [63:0]       cfg_chars      = '0;
    logic [MASK_W-1:0] cfg_any        = '0;
    logic [MASK_W-1:0] cfg_star       = '0;
    logic [LEN_W-1:0]  cfg_len        = '0;
    logic              cfg_anch_start = 1'b0;
    logic              cfg_anch_end   = 1'b0;

    // predictor copy of the matcher state
    logic [8:0] nfa_set       = 9'd1;
    logic       match_latched = 1'b0;
    logic       text_at_start = 1'b1;

    t_verdict pending_verdicts[$];
    int       mismatch_count = 0;
    int       requests_sent  = 0;
    int       burst_left     = 0;

    t_rx_mode    rx_mode    = RX_FREE;
    int          rx_left    = 0;
    logic [31:0] rx_pattern = '0;

    simple_regex_stream_matcher_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_text_char(i_text_char),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_done_res (o_done_res),
        .o_found    (o_found),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // NFA predictor
    // ------------------------------------------------------------------------
    function automatic logic [8:0] close_over_stars(logic [8:0] s, int len);
        logic [8:0] r;
        r = s;
        for (int i = len + 1; i < 9; i++) r[i] = 1'b0;
        for (int i = 0; i < len; i++) begin
            if (r[i] && cfg_star[i]) r[i+1] = 1'b1;
        end
        return r;
    endfunction

    // reached set with position zero reseeded where a new attempt may start
    function automatic logic [8:0] live_set(int len);
        logic [8:0] s;
        s = nfa_set;
        if (!cfg_anch_start || text_at_start) s[0] = 1'b1;
        return close_over_stars(s, len);
    endfunction

    task automatic predict_match(logic cmd, logic [CHAR_W-1:0] ch);
        int         len;
        logic [8:0] cur;
        logic [8:0] nxt;
        t_verdict   v;
        len = (cfg_len > 4'd8) ? 8 : int'(cfg_len);
        cur = live_set(len);
        if (cmd == CMD_END) begin
            v.done        = 1'b1;
            v.found       = cur[len] | (!cfg_anch_end & match_latched);
            nfa_set       = 9'd1;
            match_latched = 1'b0;
            text_at_start = 1'b1;
        end else begin
            if (!cfg_anch_end && cur[len]) match_latched = 1'b1;
            nxt = '0;
            for (int i = 0; i < len; i++) begin
                if (cur[i] && (cfg_any[i] || cfg_chars[8*i +: 8] == ch)) begin
                    if (cfg_star[i]) nxt[i] = 1'b1;
                    else nxt[i+1] = 1'b1;
                end
            end
            text_at_start = 1'b0;
            nfa_set       = close_over_stars(nxt, len);
            cur           = live_set(len);
            if (!cfg_anch_end && cur[len]) match_latched = 1'b1;
            v.done  = 1'b0;
            v.found = cfg_anch_end ? 1'b0 : match_latched;
        end
        pending_verdicts.push_back(v);
    endtask

    // ------------------------------------------------------------------------
    // stimulus and checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_request(logic cmd, logic [CHAR_W-1:0] ch);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid     = 1'b1;
        i_command   = cmd;
        i_text_char = ch;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predict_match(cmd, ch);
        requests_sent++;
    endtask

    task automatic send_text(t_text t);
        foreach (t[i]) send_request(CMD_CHAR, t[i]);
        send_request(CMD_END, CHAR_W'($urandom_range(0, 255)));
    endtask

    // no request in flight and every verdict back
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid    = 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            CFG_CHARS:     cfg_chars      = data;
            CFG_ANY_MASK:  cfg_any        = data[MASK_W-1:0];
            CFG_STAR_MASK: cfg_star       = data[MASK_W-1:0];
            CFG_LENGTH:    cfg_len        = data[LEN_W-1:0];
            CFG_ANCH_BEG:  cfg_anch_start = data[0];
            CFG_ANCH_END:  cfg_anch_end   = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_pattern(logic [63:0] chars, logic [7:0] any, logic [7:0] star,
                                logic [3:0] len, logic anch_s, logic anch_e);
        wait_idle();
        write_reg(CFG_CHARS, chars);
        write_reg(CFG_ANY_MASK, 64'(any));
        write_reg(CFG_STAR_MASK, 64'(star));
        write_reg(CFG_LENGTH, 64'(len));
        write_reg(CFG_ANCH_BEG, 64'(anch_s));
        write_reg(CFG_ANCH_END, 64'(anch_e));
    endtask

    function automatic logic [63:0] pack_chars(string s);
        logic [63:0] p;
        p = '0;
        for (int i = 0; i < s.len() && i < 8; i++) p[8*i +: 8] = s[i];
        return p;
    endfunction

    function automatic t_text str_text(string s);
        t_text t;
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        return t;
    endfunction

    function automatic logic [CHAR_W-1:0] random_char(logic [CHAR_W-1:0] base);
        if ($urandom_range(0, 4) == 0) return CHAR_W'($urandom_range(0, 255));
        return base + CHAR_W'($urandom_range(0, 2));
    endfunction

    // noise around an optional instance of the loaded pattern
    function automatic t_text random_text(logic [CHAR_W-1:0] base);
        t_text t;
        int    n;
        int    len;
        int    reps;
        n = $urandom_range(0, 4);
        repeat (n) t.push_back(random_char(base));
        if ($urandom_range(0, 1) == 1) begin
            len = (cfg_len > 4'd8) ? 8 : int'(cfg_len);
            for (int i = 0; i < len; i++) begin
                reps = cfg_star[i] ? $urandom_range(0, 2) : 1;
                repeat (reps)
                    t.push_back(cfg_any[i] ? random_char(base) : cfg_chars[8*i +: 8]);
            end
        end
        n = $urandom_range(0, 4);
        repeat (n) t.push_back(random_char(base));
        return t;
    endfunction

    // verdict checker
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("verdict with no request pending");
            end else begin
                want = pending_verdicts.pop_front();
                if (o_done_res !== want.done)
                    report_mismatch($sformatf("done_res %b, want %b", o_done_res, want.done));
                if (o_found !== want.found)
                    report_mismatch($sformatf("found %b, want %b (done %b)",
                                              o_found, want.found, want.done));
            end
        end
    end

    // receiver back-pressure with a randomly changing stall pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode    = t_rx_mode'($urandom_range(0, 3));
            rx_left    = $urandom_range(8, 64);
            rx_pattern = $urandom;
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:    i_ready = 1'b1;
            RX_PATTERN: i_ready = rx_pattern[rx_left % 32];
            RX_MOSTLY:  i_ready = ($urandom_range(0, 3) != 0);
            default:    i_ready = $urandom_range(0, 1);
        endcase
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_empty_pattern();
        load_pattern('0, '0, '0, 4'd0, 1'b0, 1'b0);
        send_text(str_text("x"));
        send_text(str_text(""));
    endtask

    task automatic test_literal();
        load_pattern(pack_chars("ab"), '0, '0, 4'd2, 1'b0, 1'b0);
        send_text(str_text("xab"));
    endtask

    task automatic test_star_any_anchored();
        // ^a.*b$
        load_pattern(pack_chars("a.b"), 8'b010, 8'b010, 4'd3, 1'b1, 1'b1);
        send_text(str_text("ab"));
    endtask

    task automatic test_start_anchor();
        load_pattern(pack_chars("ab"), '0, '0, 4'd2, 1'b1, 1'b0);
        send_text(str_text("xab"));
    endtask

    task automatic test_extremes();
        t_text t;
        // length above the maximum, all elements any and starred, end anchor
        load_pattern({64{1'b1}}, 8'hFF, 8'hFF, 4'd15, 1'b0, 1'b1);
        t = {8'h00, 8'hFF};
        send_text(t);
        // zero byte is an ordinary character
        load_pattern('0, '0, '0, 4'd1, 1'b0, 1'b0);
        t = {8'h00};
        send_text(t);
    endtask

    task automatic test_config_mid_text();
        load_pattern(pack_chars("ab"), '0, '0, 4'd2, 1'b0, 1'b0);
        send_request(CMD_CHAR, "a");
        wait_idle();
        // shorter pattern, the reached position now counts as a match
        write_reg(CFG_LENGTH, 64'd1);
        send_request(CMD_CHAR, "x");
        send_request(CMD_END, 8'h00);
    endtask

    task automatic test_random_streams();
        int                start;
        int                r;
        int                n_strings;
        int                split;
        logic [CHAR_W-1:0] base;
        logic [63:0]       chars;
        logic [7:0]        any;
        logic [7:0]        star;
        logic [3:0]        len;
        t_text             txt;
        start = requests_sent;
        while (requests_sent - start < RANDOM_REQUESTS) begin
            base = ($urandom_range(0, 3) == 0) ? CHAR_W'($urandom_range(0, 255)) : "a";
            if ($urandom_range(0, 7) == 0) begin
                chars = {$urandom, $urandom};
            end else begin
                for (int i = 0; i < 8; i++)
                    chars[8*i +: 8] = base + CHAR_W'($urandom_range(0, 2));
            end
            any  = '0;
            star = '0;
            for (int i = 0; i < 8; i++) begin
                any[i]  = ($urandom_range(0, 4) == 0);
                star[i] = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 9) == 0) any = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0) star = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 15);
            if (r < 10) len = 4'($urandom_range(1, 4));
            else if (r < 12) len = 4'($urandom_range(5, 8));
            else if (r == 12) len = 4'd0;
            else len = 4'($urandom_range(9, 15));
            load_pattern(chars, any, star, len, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            n_strings = $urandom_range(2, 8);
            repeat (n_strings) begin
                txt = random_text(base);
                if (txt.size() > 1 && $urandom_range(0, 11) == 0) begin
                    // reconfigure part way through a string
                    split = $urandom_range(1, txt.size() - 1);
                    for (int i = 0; i < split; i++) send_request(CMD_CHAR, txt[i]);
                    wait_idle();
                    case ($urandom_range(0, 3))
                        0: write_reg(CFG_LENGTH, 64'($urandom_range(0, 15)));
                        1: write_reg(CFG_STAR_MASK, 64'($urandom_range(0, 255)));
                        2: write_reg(CFG_ANCH_BEG, 64'($urandom_range(0, 1)));
                        default: write_reg(CFG_ANCH_END, 64'($urandom_range(0, 1)));
                    endcase
                    for (int i = split; i < txt.size(); i++) send_request(CMD_CHAR, txt[i]);
                    send_request(CMD_END, CHAR_W'($urandom_range(0, 255)));
                end else begin
                    send_text(txt);
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_pattern();
        test_literal();
        test_star_any_anchored();
        test_start_anchor();
        test_extremes();
        test_config_mid_text();
        test_random_streams();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never returned", pending_verdicts.size()));
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
